[rtl/two_order_buddy_page_allocator_top_assert.svh]
// assertion macros for the two-order buddy page allocator
// used by modules that check their own control sequencing
`ifndef TWO_ORDER_BUDDY_PAGE_ALLOCATOR_TOP_ASSERT_SVH
`define TWO_ORDER_BUDDY_PAGE_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TOBPA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define TOBPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tobpa_pkg.sv]
// shared types and constants of the two-order buddy page allocator
// no dependencies
package tobpa_pkg;

  localparam int PAGE_BYTES = 4096;
  localparam int SIZE_W     = 14;
  localparam int PAGE_W     = 10;
  localparam int CNT_W      = 2;
  localparam int MARK_W     = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [MARK_W-1:0] MARK_NONE = 2'd0;
  localparam logic [MARK_W-1:0] MARK_LOW  = 2'd1;
  localparam logic [MARK_W-1:0] MARK_HIGH = 2'd2;

  localparam logic [3:0] ACT_NONE        = 4'd0;
  localparam logic [3:0] ACT_CLEAR       = 4'd1;
  localparam logic [3:0] ACT_LATCH       = 4'd2;
  localparam logic [3:0] ACT_POP         = 4'd3;
  localparam logic [3:0] ACT_PUSH_PAIR   = 4'd4;
  localparam logic [3:0] ACT_TAKE_SINGLE = 4'd5;
  localparam logic [3:0] ACT_SPLIT       = 4'd6;
  localparam logic [3:0] ACT_GRANT_PAIR  = 4'd7;
  localparam logic [3:0] ACT_MERGE       = 4'd8;
  localparam logic [3:0] ACT_LINK_HEAD   = 4'd9;
  localparam logic [3:0] ACT_FIX_PREV    = 4'd10;
  localparam logic [3:0] ACT_FAIL        = 4'd11;

  typedef struct packed {
    logic [3:0] act;
    logic       fin;
  } cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic small_req;
    logic cnt_one;
    logic q_ok;
    logic head_valid;
    logic fill_zero;
    logic mark_set;
    logic clr_last;
  } sts_t;

endpackage

[rtl/two_order_buddy_page_allocator_top.sv]
// two-order buddy page allocator, top level: controller plus list datapath
// done is registered from the finishing controller state: issue for a pair free, an
// out-of-range free or a failed allocate, exec for an allocate or a merged single free, link for a linked single free
// a new item is accepted only while busy is low, after the previous one has finished
// reset: busy stays high while the buddy marks are cleared
// depends on tobpa_pkg, tobpa_ctrl, tobpa_dp
module two_order_buddy_page_allocator_top #(
  parameter int PAIR_COUNT = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [tobpa_pkg::SIZE_W-1:0]  request_size,
  input  logic [tobpa_pkg::PAGE_W-1:0]  page_number,
  input  logic [tobpa_pkg::CNT_W-1:0]   free_count,
  output logic                          done,
  output logic                          status,
  output logic [tobpa_pkg::PAGE_W-1:0]  granted_page,
  output logic [tobpa_pkg::CNT_W-1:0]   granted_count
);
  import tobpa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tobpa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .sts(sts), .cmd(cmd)
  );

  tobpa_dp #(.PAIR_COUNT(PAIR_COUNT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .operation(operation), .request_size(request_size),
    .page_number(page_number), .free_count(free_count),
    .status(status), .granted_page(granted_page), .granted_count(granted_count)
  );

endmodule

[rtl/tobpa_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module tobpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/tobpa_ctrl.sv]
// controller state machine of the two-order buddy page allocator
// depends on tobpa_pkg and two_order_buddy_page_allocator_top_assert.svh
`include "two_order_buddy_page_allocator_top_assert.svh"

module tobpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  input  tobpa_pkg::sts_t   sts,
  output tobpa_pkg::cmd_t   cmd
);
  import tobpa_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_EXEC  = 3'd3;
  localparam logic [2:0] ST_LINK  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd.act    = ACT_NONE;
    cmd.fin    = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.act = ACT_CLEAR;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.act    = ACT_LATCH;
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (sts.is_alloc) begin
          if (sts.small_req && sts.head_valid) begin
            state_next = ST_EXEC;
          end else if (!sts.fill_zero) begin
            cmd.act    = ACT_POP;
            state_next = ST_EXEC;
          end else begin
            cmd.act    = ACT_FAIL;
            cmd.fin    = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (!sts.q_ok) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end else if (!sts.cnt_one) begin
          cmd.act    = ACT_PUSH_PAIR;
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.is_alloc) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
          if (!sts.small_req) begin
            cmd.act = ACT_GRANT_PAIR;
          end else if (sts.head_valid) begin
            cmd.act = ACT_TAKE_SINGLE;
          end else begin
            cmd.act = ACT_SPLIT;
          end
        end else if (sts.mark_set) begin
          cmd.act    = ACT_MERGE;
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.act    = ACT_LINK_HEAD;
          state_next = ST_LINK;
        end
      end
      ST_LINK: begin
        cmd.act    = ACT_FIX_PREV;
        cmd.fin    = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.fin;
    end
  end

  assign busy = (state != ST_IDLE);

  `TOBPA_ASSERT_NEXT(a_accept_issue, clk, rst, state == ST_IDLE && start, state == ST_ISSUE, "accepted item did not enter issue")
  `TOBPA_ASSERT_NOW(a_fin_state, clk, rst, cmd.fin, state == ST_ISSUE || state == ST_EXEC || state == ST_LINK, "result finished outside item states")
  `TOBPA_ASSERT_NOW(a_link_after_exec, clk, rst, state == ST_LINK, $past(state) == ST_EXEC, "link step not preceded by exec")
  `TOBPA_ASSERT_NEXT(a_done_idle, clk, rst, cmd.fin, state == ST_IDLE && done, "finish did not return to idle with strobe")

endmodule

[rtl/tobpa_dp.sv]
// datapath: pair stack, single list links, buddy marks and result registers
// depends on tobpa_pkg and tobpa_ram
module tobpa_dp #(
  parameter int PAIR_COUNT = 512
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tobpa_pkg::cmd_t                      cmd,
  output tobpa_pkg::sts_t                      sts,
  input  logic                                 operation,
  input  logic [tobpa_pkg::SIZE_W-1:0]         request_size,
  input  logic [tobpa_pkg::PAGE_W-1:0]         page_number,
  input  logic [tobpa_pkg::CNT_W-1:0]          free_count,
  output logic                                 status,
  output logic [tobpa_pkg::PAGE_W-1:0]         granted_page,
  output logic [tobpa_pkg::CNT_W-1:0]          granted_count
);
  import tobpa_pkg::*;

  localparam int QW = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;
  localparam int LW = $clog2(PAIR_COUNT + 1);
  localparam logic [LW-1:0] NIL  = LW'(PAIR_COUNT);
  localparam logic [QW-1:0] LAST = QW'(PAIR_COUNT - 1);

  logic [LW-1:0]     fill;
  logic [LW-1:0]     lowmark;
  logic [LW-1:0]     head;
  logic [LW-1:0]     old_head;
  logic [QW-1:0]     clr_cnt;
  logic              syn;
  logic [QW-1:0]     syn_val;
  logic              op_r;
  logic              small_r;
  logic              cnt_one_r;
  logic [PAGE_W-1:0] page_r;

  logic [LW-1:0]     pos;
  logic [QW-1:0]     q_in;
  logic [QW-1:0]     cur;
  logic [QW-1:0]     stk_q;
  logic [MARK_W-1:0] half;
  logic              can_push;
  logic              push_en;
  logic              unlink_en;

  logic              stk_we;
  logic [QW-1:0]     stk_waddr;
  logic [QW-1:0]     stk_rd;
  logic              nxt_we;
  logic [QW-1:0]     nxt_waddr;
  logic [LW-1:0]     nxt_wdata;
  logic [LW-1:0]     nxt_rd;
  logic              prv_we;
  logic [QW-1:0]     prv_waddr;
  logic [LW-1:0]     prv_wdata;
  logic [LW-1:0]     prv_rd;
  logic              mark_we;
  logic [QW-1:0]     mark_waddr;
  logic [MARK_W-1:0] mark_wdata;
  logic [MARK_W-1:0] mark_rd;

  assign pos       = fill - LW'(1);
  assign q_in      = QW'(page_r[PAGE_W-1:1]);
  assign cur       = (op_r == OP_ALLOC) ? head[QW-1:0] : q_in;
  assign stk_q     = syn ? syn_val : stk_rd;
  assign half      = page_r[0] ? MARK_HIGH : MARK_LOW;
  assign can_push  = (fill < NIL);
  assign push_en   = (cmd.act == ACT_PUSH_PAIR) || (cmd.act == ACT_MERGE);
  assign unlink_en = (cmd.act == ACT_TAKE_SINGLE) || (cmd.act == ACT_MERGE);

  assign sts.is_alloc   = (op_r == OP_ALLOC);
  assign sts.small_req  = small_r;
  assign sts.cnt_one    = cnt_one_r;
  assign sts.q_ok       = (32'(page_r[PAGE_W-1:1]) < 32'(PAIR_COUNT));
  assign sts.head_valid = (head != NIL);
  assign sts.fill_zero  = (fill == '0);
  assign sts.mark_set   = (mark_rd != MARK_NONE);
  assign sts.clr_last   = (clr_cnt == LAST);

  always_comb begin
    stk_we     = push_en && can_push;
    stk_waddr  = fill[QW-1:0];
    nxt_we     = 1'b0;
    nxt_waddr  = cur;
    nxt_wdata  = nxt_rd;
    prv_we     = 1'b0;
    prv_waddr  = cur;
    prv_wdata  = prv_rd;
    mark_we    = 1'b0;
    mark_waddr = cur;
    mark_wdata = MARK_NONE;
    if (unlink_en) begin
      nxt_we    = (prv_rd != NIL);
      nxt_waddr = prv_rd[QW-1:0];
      nxt_wdata = nxt_rd;
      prv_we    = (nxt_rd != NIL);
      prv_waddr = nxt_rd[QW-1:0];
      prv_wdata = prv_rd;
      mark_we   = 1'b1;
    end
    case (cmd.act)
      ACT_CLEAR: begin
        mark_we    = 1'b1;
        mark_waddr = clr_cnt;
      end
      ACT_SPLIT: begin
        nxt_we     = 1'b1;
        nxt_waddr  = stk_q;
        nxt_wdata  = NIL;
        prv_we     = 1'b1;
        prv_waddr  = stk_q;
        prv_wdata  = NIL;
        mark_we    = 1'b1;
        mark_waddr = stk_q;
        mark_wdata = MARK_HIGH;
      end
      ACT_LINK_HEAD: begin
        nxt_we     = 1'b1;
        nxt_waddr  = q_in;
        nxt_wdata  = head;
        prv_we     = 1'b1;
        prv_waddr  = q_in;
        prv_wdata  = NIL;
        mark_we    = 1'b1;
        mark_waddr = q_in;
        mark_wdata = half;
      end
      ACT_FIX_PREV: begin
        prv_we    = (old_head != NIL);
        prv_waddr = old_head[QW-1:0];
        prv_wdata = LW'(q_in);
      end
      default: begin
      end
    endcase
  end

  tobpa_ram #(.WIDTH(QW), .DEPTH(PAIR_COUNT)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(cur),
    .raddr(pos[QW-1:0]), .rdata(stk_rd)
  );

  tobpa_ram #(.WIDTH(LW), .DEPTH(PAIR_COUNT)) u_nxt (
    .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(cur), .rdata(nxt_rd)
  );

  tobpa_ram #(.WIDTH(LW), .DEPTH(PAIR_COUNT)) u_prv (
    .clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
    .raddr(cur), .rdata(prv_rd)
  );

  tobpa_ram #(.WIDTH(MARK_W), .DEPTH(PAIR_COUNT)) u_mark (
    .clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
    .raddr(cur), .rdata(mark_rd)
  );

  // stack entries below the low-water mark were never written; a pop there returns its own index
  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= NIL;
      lowmark  <= NIL;
      head     <= NIL;
      clr_cnt  <= '0;
    end else begin
      if (cmd.act == ACT_CLEAR) begin
        clr_cnt <= clr_cnt + QW'(1);
      end
      if (cmd.act == ACT_POP) begin
        fill <= pos;
        if (pos < lowmark) begin
          lowmark <= pos;
        end
      end
      if (push_en && can_push) begin
        fill <= fill + LW'(1);
      end
      if (unlink_en && (prv_rd == NIL)) begin
        head <= nxt_rd;
      end
      if (cmd.act == ACT_SPLIT) begin
        head <= LW'(stk_q);
      end
      if (cmd.act == ACT_LINK_HEAD) begin
        head <= LW'(q_in);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.act == ACT_LATCH) begin
      op_r      <= operation;
      small_r   <= (32'(request_size) <= 32'(PAGE_BYTES));
      cnt_one_r <= (free_count == CNT_W'(1));
      page_r    <= page_number;
    end
    if (cmd.act == ACT_POP) begin
      syn     <= (pos < lowmark);
      syn_val <= pos[QW-1:0];
    end
    if (cmd.act == ACT_LINK_HEAD) begin
      old_head <= head;
    end
    if (cmd.fin) begin
      status        <= (cmd.act == ACT_FAIL);
      granted_page  <= '0;
      granted_count <= '0;
      case (cmd.act)
        ACT_TAKE_SINGLE: begin
          granted_page  <= PAGE_W'({cur, mark_rd == MARK_HIGH});
          granted_count <= CNT_W'(1);
        end
        ACT_SPLIT: begin
          granted_page  <= PAGE_W'({stk_q, 1'b0});
          granted_count <= CNT_W'(1);
        end
        ACT_GRANT_PAIR: begin
          granted_page  <= PAGE_W'({stk_q, 1'b0});
          granted_count <= CNT_W'(2);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[verif/two_order_buddy_page_allocator_top_tb.sv]
// self-checking testbench for two_order_buddy_page_allocator_top
// a directed table, then random alloc/free traffic with a full drain, checked against the
// table results or an in-bench model of the pair stack and single list; needs tobpa_pkg
`timescale 1ns / 100ps

module two_order_buddy_page_allocator_top_tb;
  import tobpa_pkg::*;

  localparam int PAIR_COUNT = 512;
  localparam logic [PAGE_W-1:0] NIL = PAGE_W'(PAIR_COUNT);
  localparam int IDLE_LIMIT = 4000;

  localparam logic ST_DONE   = 1'b0;
  localparam logic ST_NO_MEM = 1'b1;

  localparam logic [CNT_W-1:0] FREE_SINGLE = 2'd1;
  localparam logic [CNT_W-1:0] FREE_PAIR   = 2'd2;

  typedef struct packed {
    logic              status;
    logic [PAGE_W-1:0] page;
    logic [CNT_W-1:0]  count;
  } grant_t;

  typedef struct packed {
    logic              op;
    logic [SIZE_W-1:0] size;
    logic [PAGE_W-1:0] page;
    logic [CNT_W-1:0]  cnt;
    logic              typed;
    grant_t            want;
  } stim_row_t;

  localparam grant_t NO_GRANT = '{ST_DONE, 10'd0, 2'd0};
  localparam int N_DIRECTED = 19;

  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{OP_FREE,  14'd0,     10'd0,    FREE_PAIR,   1'b1, NO_GRANT},
    '{OP_ALLOC, 14'd0,     10'd0,    FREE_PAIR,   1'b1, '{ST_DONE, 10'd1022, 2'd1}},
    '{OP_ALLOC, 14'd4096,  10'd0,    FREE_PAIR,   1'b1, '{ST_DONE, 10'd1023, 2'd1}},
    '{OP_ALLOC, 14'd4097,  10'd0,    FREE_PAIR,   1'b1, '{ST_DONE, 10'd1020, 2'd2}},
    '{OP_ALLOC, 14'h3fff,  10'h3ff,  2'd3,        1'b1, '{ST_DONE, 10'd1018, 2'd2}},
    '{OP_FREE,  14'd0,     10'd1023, FREE_SINGLE, 1'b1, NO_GRANT},
    '{OP_FREE,  14'h3fff,  10'd1022, FREE_SINGLE, 1'b1, NO_GRANT},
    '{OP_ALLOC, 14'd1,     10'd0,    FREE_SINGLE, 1'b0, NO_GRANT},
    '{OP_FREE,  14'd0,     10'd1021, FREE_PAIR,   1'b0, NO_GRANT},
    '{OP_ALLOC, 14'd8192,  10'd0,    FREE_PAIR,   1'b0, NO_GRANT},
    '{OP_FREE,  14'd0,     10'd1022, FREE_SINGLE, 1'b0, NO_GRANT},
    '{OP_ALLOC, 14'd0,     10'd0,    FREE_SINGLE, 1'b0, NO_GRANT},
    '{OP_ALLOC, 14'd0,     10'd0,    FREE_SINGLE, 1'b0, NO_GRANT},
    '{OP_FREE,  14'd0,     10'd1022, FREE_SINGLE, 1'b0, NO_GRANT},
    '{OP_FREE,  14'd0,     10'd1022, FREE_SINGLE, 1'b0, NO_GRANT},
    '{OP_FREE,  14'd0,     10'd1019, 2'd0,        1'b0, NO_GRANT},
    '{OP_FREE,  14'd0,     10'd1023, 2'd3,        1'b0, NO_GRANT},
    '{OP_ALLOC, 14'h3fff,  10'd0,    2'd0,        1'b0, NO_GRANT},
    '{OP_FREE,  14'd0,     10'd0,    FREE_SINGLE, 1'b0, NO_GRANT}
  };

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              operation;
  logic [SIZE_W-1:0] request_size;
  logic [PAGE_W-1:0] page_number;
  logic [CNT_W-1:0]  free_count;
  logic              done;
  logic              status;
  logic [PAGE_W-1:0] granted_page;
  logic [CNT_W-1:0]  granted_count;

  two_order_buddy_page_allocator_top #(
    .PAIR_COUNT(PAIR_COUNT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .request_size(request_size),
    .page_number(page_number),
    .free_count(free_count),
    .done(done),
    .status(status),
    .granted_page(granted_page),
    .granted_count(granted_count)
  );

  // allocator image
  logic [8:0]        pair_stack_mem [PAIR_COUNT];
  logic [PAGE_W-1:0] stack_fill;
  logic [PAGE_W-1:0] link_next [PAIR_COUNT];
  logic [PAGE_W-1:0] link_prev [PAIR_COUNT];
  logic [PAGE_W-1:0] single_top;
  logic [MARK_W-1:0] half_mark [PAIR_COUNT];

  grant_t            pending_grants [$];
  grant_t            last_grant;
  logic [PAGE_W-1:0] held_pages [$];
  logic [CNT_W-1:0]  held_counts [$];

  bit     quiet;
  int     errors;
  int     idle_cycles;
  int     n_items, n_alloc, n_free, n_no_mem, n_checked;
  logic   seen_done;
  grant_t seen_grant;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void unlink_single(input logic [8:0] q);
    logic [PAGE_W-1:0] n;
    logic [PAGE_W-1:0] p;
    n = link_next[q];
    p = link_prev[q];
    if (p == NIL) single_top = n;
    else link_next[p[8:0]] = n;
    if (n != NIL) link_prev[n[8:0]] = p;
    half_mark[q] = MARK_NONE;
  endfunction

  function automatic void push_single(input logic [8:0] q, input logic [MARK_W-1:0] half);
    if (half_mark[q] != MARK_NONE) unlink_single(q);
    link_next[q] = single_top;
    link_prev[q] = NIL;
    if (single_top != NIL) link_prev[single_top[8:0]] = {1'b0, q};
    single_top = {1'b0, q};
    half_mark[q] = half;
  endfunction

  function automatic void push_pair(input logic [8:0] q);
    if (stack_fill < PAIR_COUNT) begin
      pair_stack_mem[stack_fill[8:0]] = q;
      stack_fill = stack_fill + 1'b1;
    end
  endfunction

  function automatic grant_t predict_grant(input logic op, input logic [SIZE_W-1:0] size,
                                           input logic [PAGE_W-1:0] page,
                                           input logic [CNT_W-1:0] cnt);
    grant_t g;
    logic [8:0] q;
    int pair_idx;
    g = NO_GRANT;
    if (op == OP_ALLOC) begin
      if (size <= PAGE_BYTES) begin
        if (single_top != NIL) begin
          q = single_top[8:0];
          g.page = {q, half_mark[q] == MARK_HIGH};
          unlink_single(q);
          g.count = 2'd1;
        end else if (stack_fill != 0) begin
          stack_fill = stack_fill - 1'b1;
          q = pair_stack_mem[stack_fill[8:0]];
          push_single(q, MARK_HIGH);
          g.page = {q, 1'b0};
          g.count = 2'd1;
        end else begin
          g.status = ST_NO_MEM;
        end
      end else begin
        if (stack_fill != 0) begin
          stack_fill = stack_fill - 1'b1;
          g.page = {pair_stack_mem[stack_fill[8:0]], 1'b0};
          g.count = 2'd2;
        end else begin
          g.status = ST_NO_MEM;
        end
      end
    end else begin
      pair_idx = int'(page >> 1);
      q = page[PAGE_W-1:1];
      if (pair_idx < PAIR_COUNT) begin
        if (cnt == FREE_SINGLE) begin
          if (half_mark[q] != MARK_NONE) begin
            unlink_single(q);
            push_pair(q);
          end else begin
            push_single(q, page[0] ? MARK_HIGH : MARK_LOW);
          end
        end else begin
          push_pair(q);
        end
      end
    end
    return g;
  endfunction

  task automatic issue(input logic op, input logic [SIZE_W-1:0] size,
                       input logic [PAGE_W-1:0] page, input logic [CNT_W-1:0] cnt,
                       input logic typed, input grant_t want);
    int gap;
    @(negedge clk);
    start        <= 1'b1;
    operation    <= op;
    request_size <= size;
    page_number  <= page;
    free_count   <= cnt;
    do @(posedge clk); while (busy !== 1'b0);
    last_grant = predict_grant(op, size, page, cnt);
    pending_grants.push_back(typed ? want : last_grant);
    n_items++;
    if (op == OP_ALLOC) begin
      n_alloc++;
      if (last_grant.status == ST_NO_MEM) n_no_mem++;
    end else begin
      n_free++;
    end
    gap = quiet ? 0 : $urandom_range(19);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_all_granted();
    @(negedge clk);
    start <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  task automatic alloc_item(input int large_pct);
    logic [SIZE_W-1:0] size;
    if ($urandom_range(99) < large_pct)
      size = SIZE_W'($urandom_range(2 * PAGE_BYTES, PAGE_BYTES + 1));
    else size = SIZE_W'($urandom_range(PAGE_BYTES, 0));
    issue(OP_ALLOC, size, PAGE_W'($urandom), CNT_W'($urandom), 1'b0, NO_GRANT);
    if (last_grant.status == ST_DONE) begin
      held_pages.push_back(last_grant.page);
      held_counts.push_back(last_grant.count);
    end
  endtask

  task automatic random_item(input int alloc_pct, input int large_pct);
    logic              op;
    logic [SIZE_W-1:0] size;
    logic [PAGE_W-1:0] page;
    logic [CNT_W-1:0]  cnt;
    logic [PAGE_W-1:0] base;
    logic [CNT_W-1:0]  held;
    logic              half;
    int                pick;
    int                idx;
    pick = $urandom_range(99);
    if (pick < 6) begin
      // noise: any field value at all
      op = 1'($urandom);
      size = SIZE_W'($urandom);
      page = PAGE_W'($urandom);
      cnt = CNT_W'($urandom);
      issue(op, size, page, cnt, 1'b0, NO_GRANT);
      if (op == OP_ALLOC && last_grant.status == ST_DONE) begin
        held_pages.push_back(last_grant.page);
        held_counts.push_back(last_grant.count);
      end
    end else if (pick < 6 + alloc_pct || held_pages.size() == 0) begin
      alloc_item(large_pct);
    end else begin
      idx = $urandom_range(held_pages.size() - 1);
      base = held_pages[idx];
      held = held_counts[idx];
      held_pages.delete(idx);
      held_counts.delete(idx);
      if (held == 2'd1) begin
        page = base;
        cnt = FREE_SINGLE;
      end else if ($urandom_range(9) < 3) begin
        // give back one half now, keep the buddy for later
        half = 1'($urandom_range(1));
        page = {base[PAGE_W-1:1], half};
        cnt = FREE_SINGLE;
        held_pages.push_back({base[PAGE_W-1:1], ~half});
        held_counts.push_back(2'd1);
      end else begin
        page = {base[PAGE_W-1:1], 1'($urandom_range(1))};
        if ($urandom_range(9) == 0) cnt = $urandom_range(1) ? 2'd0 : 2'd3;
        else cnt = FREE_PAIR;
      end
      issue(OP_FREE, SIZE_W'($urandom), page, cnt, 1'b0, NO_GRANT);
    end
  endtask

  task automatic run_segment(input int n, input int alloc_pct, input int large_pct);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(3) == 0);
      random_item(alloc_pct, large_pct);
    end
  endtask

  // results: sampled at the rising edge, compared at the falling edge
  always @(posedge clk) begin
    seen_done  <= !rst && (done === 1'b1);
    seen_grant <= {status, granted_page, granted_count};
  end

  always @(negedge clk) begin
    grant_t want;
    if (seen_done) begin
      if (pending_grants.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        want = pending_grants.pop_front();
        n_checked++;
        if (seen_grant.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, seen_grant.status);
          errors++;
        end
        if (seen_grant.page !== want.page) begin
          $error("granted_page: expected %0d, got %0d", want.page, seen_grant.page);
          errors++;
        end
        if (seen_grant.count !== want.count) begin
          $error("granted_count: expected %0d, got %0d", want.count, seen_grant.count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    operation    = OP_ALLOC;
    request_size = '0;
    page_number  = '0;
    free_count   = '0;
    errors       = 0;
    idle_cycles  = 0;
    quiet        = 1'b0;
    n_items      = 0;
    n_alloc      = 0;
    n_free       = 0;
    n_no_mem     = 0;
    n_checked    = 0;
    for (int i = 0; i < PAIR_COUNT; i++) begin
      pair_stack_mem[i] = 9'(i);
      link_next[i] = '0;
      link_prev[i] = '0;
      half_mark[i] = MARK_NONE;
    end
    stack_fill = PAGE_W'(PAIR_COUNT);
    single_top = NIL;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++)
      issue(DIRECTED[i].op, DIRECTED[i].size, DIRECTED[i].page, DIRECTED[i].cnt,
            DIRECTED[i].typed, DIRECTED[i].want);
    wait_all_granted();

    run_segment(80, 60, 40);

    // take every page, then ask for more
    quiet = ($urandom_range(1) == 0);
    while (stack_fill != 0 || single_top != NIL) alloc_item(85);
    alloc_item(0);
    alloc_item(100);
    alloc_item(0);
    alloc_item(100);
    wait_all_granted();

    run_segment(100, 20, 40);
    run_segment(120, 50, 30);

    wait_all_granted();
    repeat (10) @(posedge clk);
    if (pending_grants.size() != 0) begin
      $error("%0d results never arrived", pending_grants.size());
      errors++;
    end

    $display("covered %0d items: %0d allocations (%0d refused, region drained once), %0d frees",
             n_items, n_alloc, n_no_mem, n_free);
    $display("%0d results checked, %0d mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
